// ===== hw/rtl/vsd_pkg.sv =====
package vsd_pkg;

   localparam int VALUE_BITS_DEFAULT = 64;

   localparam int BYTE_BITS  = 8;
   localparam int GROUP_BITS = 7;
   localparam int OUT_VALUE_BITS = 64;
   localparam int LEN_BITS   = 8;
   localparam int STATUS_BITS = 2;

   localparam logic [BYTE_BITS-1:0] STOP_MASK = 8'b1000_0000;
   localparam logic [BYTE_BITS-1:0] DATA_MASK = 8'b0111_1111;
   localparam logic [LEN_BITS-1:0]  LEN_MAX   = 8'b1111_1111;

   localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_NO_STOP  = 2'd2;

   typedef struct packed {
      logic                 buffer_end;
      logic [BYTE_BITS-1:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [LEN_BITS-1:0]       rec_len;
      logic [STATUS_BITS-1:0]    status;
      logic [OUT_VALUE_BITS-1:0] value;
   } result_type;

endpackage

// ===== hw/rtl/vsd_step.sv =====
module vsd_step
   import vsd_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   output logic       emit,
   output result_type result
);

   localparam int NUM_GROUPS = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
   localparam int GRP_W      = $clog2(NUM_GROUPS);
   localparam int EXT_W      = VALUE_BITS + GROUP_BITS;
   localparam int POS_W      = $clog2(EXT_W);

   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [LEN_BITS-1:0]   index_ff, index_in;
   logic                  large_ff, large_in;

   logic [GROUP_BITS-1:0] data;
   logic                  in_range;
   logic [GRP_W-1:0]      kidx;
   logic [POS_W-1:0]      pos;
   logic [EXT_W-1:0]      shifted;
   logic [LEN_BITS-1:0]   len;
   logic                  large_now;
   logic [VALUE_BITS-1:0] acc_now;
   logic                  stop;

   always_comb begin
      data     = item.data_byte[GROUP_BITS-1:0] & DATA_MASK[GROUP_BITS-1:0];
      stop     = (item.data_byte & STOP_MASK) != '0;
      in_range = index_ff < LEN_BITS'(NUM_GROUPS);
      kidx     = index_ff[GRP_W-1:0];
      pos      = POS_W'(GROUP_BITS * int'(kidx));
      shifted  = EXT_W'(data) << pos;

      if (in_range) begin
         acc_now   = acc_ff | shifted[VALUE_BITS-1:0];
         large_now = large_ff | (shifted[EXT_W-1:VALUE_BITS] != '0);
      end else begin
         acc_now   = acc_ff;
         large_now = large_ff | (data != '0);
      end

      len = (index_ff == LEN_MAX) ? LEN_MAX : index_ff + LEN_BITS'(1);

      emit   = stop | item.buffer_end;
      result = '0;
      if (stop) begin
         result.status  = large_now ? ST_OVERFLOW : ST_OK;
         result.value   = large_now ? '0 : OUT_VALUE_BITS'(acc_now);
         result.rec_len = len;
      end else begin
         result.status = ST_NO_STOP;
      end

      acc_in   = acc_ff;
      index_in = index_ff;
      large_in = large_ff;
      if (advance) begin
         if (emit) begin
            acc_in   = '0;
            index_in = '0;
            large_in = 1'b0;
         end else begin
            acc_in   = acc_now;
            index_in = len;
            large_in = large_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         index_ff <= '0;
         large_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         index_ff <= index_in;
         large_ff <= large_in;
      end
   end

endmodule

// ===== hw/rtl/varint_stop_bit_decoder_top.sv =====
// varint decoder, 7-bit groups least significant first, bit 7 marks the
// last byte of a record.
// req channel: one record byte per transfer on req_tdata, req_tlast set on
// the last byte of the available buffer.
// rsp channel: one transfer per record: value and record length on
// rsp_tdata, status on rsp_tuser (ok, overflow, buffer ended without stop).
// a byte is registered on entry and then decoded straight into the output
// register; a result is offered once the stop byte reaches it. one byte is
// taken every cycle but while a record end waits on a full output register.
// the rate is set by the single decode stage between the input register and
// the output register, which holds the record state.
// when rsp_tready is low the output register holds its result; the input
// register still takes a byte, and further bytes wait only if that byte
// would finish a record while the output register is full.
// reset clears both valid flags and the record state; no clearing pass.
module varint_stop_bit_decoder_top
   import vsd_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // buffer_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // value [63:0], rec_len [71:64]
   output logic [1:0]  rsp_tuser    // status
);

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   logic       advance;
   logic       emit;
   result_type result;
   logic       out_free;

   vsd_step #(
      .VALUE_BITS(VALUE_BITS)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .emit    (emit),
      .result  (result)
   );

   always_comb begin
      out_free   = !out_valid_ff || rsp_tready;
      // a byte that closes nothing can always move on
      advance    = in_valid_ff && (!emit || out_free);
      req_tready = !in_valid_ff || advance;

      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_item_in  = '{buffer_end: req_tlast, data_byte: req_tdata};
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_free) begin
         out_valid_in = advance && emit;
         out_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff <= in_item_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.rec_len, out_ff.value};
   assign rsp_tuser  = out_ff.status;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench
   import vsd_pkg::*;
();

   localparam int VBITS = VALUE_BITS_DEFAULT;

   // decodes the byte stream on its own and keeps the records still owed by the block
   class record_tracker;
      logic [63:0]   acc;
      logic [7:0]    byte_count;
      bit            too_big;
      result_type    pending_records[$];
      int            errors;
      int            n_ok;
      int            n_overflow;
      int            n_no_stop;

      function new();
         clear_record();
      endfunction

      function void clear_record();
         acc        = '0;
         byte_count = '0;
         too_big    = 1'b0;
      endfunction

      // called for every accepted byte
      function void absorb_byte(logic [7:0] b, logic buf_end);
         logic [6:0]  grp;
         logic [70:0] placed;
         logic [63:0] vmask;
         int          pos;
         result_type  r;
         grp = b[6:0] & DATA_MASK[6:0];
         pos = 7 * int'(byte_count);
         vmask = (VBITS >= 64) ? '1 : ((64'd1 << VBITS) - 64'd1);
         if (grp != 0) begin
            if (pos >= VBITS) begin
               too_big = 1'b1;
            end else begin
               placed = 71'(grp) << pos;
               acc |= placed[63:0] & vmask;
               if ((placed >> VBITS) != 0) too_big = 1'b1;
            end
         end
         if (byte_count != LEN_MAX) byte_count++;
         if ((b & STOP_MASK) != 0) begin
            r.value   = too_big ? 64'd0 : acc;
            r.status  = too_big ? ST_OVERFLOW : ST_OK;
            r.rec_len = byte_count;
            pending_records.push_back(r);
            clear_record();
         end else if (buf_end) begin
            r.value   = 64'd0;
            r.status  = ST_NO_STOP;
            r.rec_len = 8'd0;
            pending_records.push_back(r);
            clear_record();
         end
      endfunction

      function void check_record(logic [71:0] tdata, logic [1:0] tuser);
         result_type want;
         if (pending_records.size() == 0) begin
            $error("record out with none expected: value %h status %0d length %0d",
                   tdata[63:0], tuser, tdata[71:64]);
            errors++;
            return;
         end
         want = pending_records.pop_front();
         if (tdata[63:0] !== want.value) begin
            $error("value: expected %h, got %h", want.value, tdata[63:0]);
            errors++;
         end
         if (tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, tuser);
            errors++;
         end
         if (tdata[71:64] !== want.rec_len) begin
            $error("rec_len: expected %0d, got %0d", want.rec_len,
                   tdata[71:64]);
            errors++;
         end
         case (want.status)
            ST_OK:       n_ok++;
            ST_OVERFLOW: n_overflow++;
            default:     n_no_stop++;
         endcase
      endfunction

      function int outstanding();
         return pending_records.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   record_tracker tracker = new();
   bit            gaps_on = 1'b1;
   bit            stalls_on = 1'b1;
   int            n_sent = 0;

   varint_stop_bit_decoder_top #(.VALUE_BITS(VBITS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one byte transfer, with an optional idle burst in front of it
   task automatic send_byte(input logic [7:0] b, input logic buf_end);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= buf_end;
      do @(posedge clock); while (!req_tready);
      tracker.absorb_byte(b, buf_end);
      n_sent++;
   endtask

   // one record of random groups; broken records hit the buffer end before a stop
   task automatic send_record(input int len, input bit broken, input bit hi_zero);
      logic [7:0] b;
      for (int k = 0; k < len; k++) begin
         b = 8'($urandom_range(0, 127));
         if (hi_zero && k >= 9) b[6:0] = (k == 9) ? 7'($urandom_range(0, 1)) : 7'd0;
         if (k == len - 1) begin
            if (broken) send_byte(b, 1'b1);
            else send_byte(b | STOP_MASK, $urandom_range(0, 3) == 0);
         end else begin
            send_byte(b, 1'b0);
         end
      end
   endtask

   // receiver: ready runs broken by stall bursts
   initial begin
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (stalls_on && $urandom_range(0, 1) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_record(rsp_tdata, rsp_tuser);
   end

   initial begin
      int pick;
      int len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // all zero, single byte
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFF, 1'b0);
      // largest value: top group carries only bit 63
      repeat (9) send_byte(8'h7F, 1'b0);
      send_byte(8'h81, 1'b0);
      // one bit too many in the top group
      repeat (9) send_byte(8'h7F, 1'b0);
      send_byte(8'h82, 1'b0);
      // zero groups well above 64 bits are harmless
      send_byte(8'h01, 1'b0);
      repeat (11) send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      // set bit above the top group
      repeat (10) send_byte(8'h00, 1'b0);
      send_byte(8'h81, 1'b0);
      // stop byte that also ends the buffer
      send_byte(8'h85, 1'b1);
      // buffer ends without stop
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b1);
      send_byte(8'h00, 1'b1);
      // length saturates, with a set bit at the saturated position
      repeat (256) send_byte(8'h00, 1'b0);
      send_byte(8'hC0, 1'b0);

      while (n_sent < 700) begin
         if (n_sent > 620) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         pick = $urandom_range(0, 99);
         len  = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 7);
         if (pick < 72) begin
            send_record(len, 1'b0, 1'($urandom_range(0, 1)));
         end else if (pick < 84) begin
            send_record(len, 1'b1, 1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(1, 6))
               send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end
      end
      req_tvalid <= 1'b0;

      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("sent %0d bytes; records checked: %0d ok, %0d overflow, %0d no stop",
               n_sent, tracker.n_ok, tracker.n_overflow, tracker.n_no_stop);
      if (tracker.errors == 0 && tracker.outstanding() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/vsd_pkg.sv
hw/rtl/vsd_step.sv
hw/rtl/varint_stop_bit_decoder_top.sv
tb/testbench.sv
